[rtl/ema_deviation_regulator_macros.svh]
// assertion helpers shared by the rtl files
`ifndef EMA_DEVIATION_REGULATOR_MACROS_SVH
`define EMA_DEVIATION_REGULATOR_MACROS_SVH

// property checked on every clock edge outside reset
`define EDA_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// property checked on every clock edge, reset included
`define EDA_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/eda_pkg.sv]
`default_nettype none

package eda_pkg;

   // register map
   typedef enum logic [2:0] {
      REG_ENABLE      = 3'd0,
      REG_SMOOTHING   = 3'd1,
      REG_BAND_SCALE  = 3'd2,
      REG_SIGMA_FLOOR = 3'd3,
      REG_WARMUP      = 3'd4,
      REG_STALL_COUNT = 3'd5,
      REG_STALL_MEAN  = 3'd6,
      REG_STALL_PUSH  = 3'd7
   } reg_index_type;

   localparam logic        RST_ENABLE      = 1'b1;
   localparam logic [15:0] RST_SMOOTHING   = 16'd3277;
   localparam logic [11:0] RST_BAND_SCALE  = 12'd512;
   localparam logic [15:0] RST_SIGMA_FLOOR = 16'd1311;
   localparam logic [15:0] RST_WARMUP      = 16'd20;
   localparam logic [15:0] RST_STALL_COUNT = 16'd200;
   localparam logic [15:0] RST_STALL_MEAN  = 16'd22938;
   localparam logic [15:0] RST_STALL_PUSH  = 16'd16384;

   // iterative unit operation
   typedef enum logic {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_status_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE,
      S_EFF_GO,
      S_EFF_WAIT,
      S_SIZE_GO,
      S_SIZE_WAIT,
      S_SCORE,
      S_MEAN,
      S_SQ,
      S_T1,
      S_DEV2,
      S_T2,
      S_ROOT_GO,
      S_ROOT_WAIT,
      S_CHECK,
      S_DEN,
      S_QUOT_GO,
      S_QUOT_WAIT,
      S_FINAL,
      S_OUT
   } seq_state_type;

   localparam logic [15:0] Q_ONE     = 16'h8000;
   localparam logic [15:0] Q_MAX_POS = 16'h7FFF;

endpackage

`default_nettype wire

[rtl/eda_ifaces.sv]
`default_nettype none

// input word channel
interface eda_req_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] edge_count;
   logic signed [16:0] word_count;
   modport source (output valid, edge_count, word_count, input ready);
   modport sink   (input valid, edge_count, word_count, output ready);
endinterface

// result word channel
interface eda_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] score;
   logic signed [15:0] regulation;
   logic        [15:0] mean_now;
   logic        [15:0] sigma_now;
   logic        [15:0] count_now;
   modport source (output valid, score, regulation, mean_now, sigma_now, count_now,
                   input ready);
   modport sink   (input valid, score, regulation, mean_now, sigma_now, count_now,
                   output ready);
endinterface

`default_nettype wire

[rtl/ema_deviation_regulator.sv]
// ema_deviation_regulator
// Takes words of (edge_count, word_count) on req_if and returns one result word
// on rsp_if per word while enabled: quality score, moving mean and sigma after
// the update, sample count and a saturated Q1.15 regulation drive.
// With enable at zero a request word is taken and dropped, no result follows.
// One word is processed at a time: req_if.ready is high only while idle.
// The first sample skips the moving update, and during warm-up the regulation
// quotient is skipped. Most of the work is done by one shared divide /
// square-root unit (16 steps per use, up to four uses) and one shared
// multiplier used in six steps.
// A result stays on rsp_if until taken; the block waits while the receiver stalls,
// and takes the next request only after the result has gone.
// Configuration goes over the APB-style port (register i at byte 4*i, no wait
// states); the user must write it only while idle, the block does not enforce it.
// Reset (synchronous, active high) restores register defaults and clears mean,
// sigma and sample count; the block is ready in the cycle after reset.
`default_nettype none
`include "ema_deviation_regulator_macros.svh"

module ema_deviation_regulator import eda_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   eda_req_if.sink          req_if,
   eda_rsp_if.source        rsp_if,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int CW = (COUNT_BITS > 17) ? COUNT_BITS : 17;

   // configuration registers
   logic        enable_ff;
   logic [15:0] smoothing_ff;
   logic [11:0] band_ff;
   logic [15:0] floor_ff;
   logic [15:0] warmup_ff;
   logic [15:0] stall_cnt_ff;
   logic [15:0] stall_mean_ff;
   logic [15:0] stall_push_ff;

   reg_index_type csr_idx;
   logic          csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = reg_index_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= RST_ENABLE;
         smoothing_ff  <= RST_SMOOTHING;
         band_ff       <= RST_BAND_SCALE;
         floor_ff      <= RST_SIGMA_FLOOR;
         warmup_ff     <= RST_WARMUP;
         stall_cnt_ff  <= RST_STALL_COUNT;
         stall_mean_ff <= RST_STALL_MEAN;
         stall_push_ff <= RST_STALL_PUSH;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ENABLE:      enable_ff     <= pwdata[0];
            REG_SMOOTHING:   smoothing_ff  <= pwdata[15:0];
            REG_BAND_SCALE:  band_ff       <= pwdata[11:0];
            REG_SIGMA_FLOOR: floor_ff      <= pwdata[15:0];
            REG_WARMUP:      warmup_ff     <= pwdata[15:0];
            REG_STALL_COUNT: stall_cnt_ff  <= pwdata[15:0];
            REG_STALL_MEAN:  stall_mean_ff <= pwdata[15:0];
            REG_STALL_PUSH:  stall_push_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         REG_ENABLE:      prdata = {31'd0, enable_ff};
         REG_SMOOTHING:   prdata = {16'd0, smoothing_ff};
         REG_BAND_SCALE:  prdata = {20'd0, band_ff};
         REG_SIGMA_FLOOR: prdata = {16'd0, floor_ff};
         REG_WARMUP:      prdata = {16'd0, warmup_ff};
         REG_STALL_COUNT: prdata = {16'd0, stall_cnt_ff};
         REG_STALL_MEAN:  prdata = {16'd0, stall_mean_ff};
         REG_STALL_PUSH:  prdata = {16'd0, stall_push_ff};
         default:         prdata = '0;
      endcase
   end

   // sequencer and datapath registers
   seq_state_type   st_ff, st_in;
   logic [15:0]     e_ff, e_in;
   logic [15:0]     w_ff, w_in;
   logic [15:0]     eff_ff, eff_in;
   logic [15:0]     score_ff, score_in;
   logic            dev_neg_ff, dev_neg_in;
   logic [15:0]     dev_mag_ff, dev_mag_in;
   logic [15:0]     mean_ff, mean_in;
   logic [15:0]     sigma_ff, sigma_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [31:0]     prod_ff, prod_in;
   logic [48:0]     acc_ff, acc_in;
   logic [27:0]     den_ff, den_in;
   logic            num_neg_ff, num_neg_in;
   logic [15:0]     mag_ff, mag_in;
   logic [15:0]     q_ff, q_in;
   logic [15:0]     reg_ff, reg_in;

   iter_ctrl_type   it_ctrl;
   iter_status_type it_status;
   logic [28:0]     it_rem0;
   logic [27:0]     it_den;
   logic [15:0]     it_result;

   logic            req_take;
   logic            first_sample;
   logic            warm;
   logic            stall_hit;
   logic [CW-1:0]   cnt_w;

   // shared multiplier
   logic [16:0]     mul_a;
   logic [31:0]     mul_b;
   logic [48:0]     mul_p;

   // score and mean arithmetic
   logic [16:0]     score_sum;
   logic [15:0]     score_c;
   logic [16:0]     dev_c;
   logic [33:0]     p_ceil;
   logic signed [18:0] mean_new;
   logic [15:0]     mean_sat;
   logic [15:0]     sig_sel;
   logic [16:0]     num_c;

   assign req_take     = req_if.valid && req_if.ready;
   assign first_sample = (cnt_ff == '0);
   assign cnt_w        = CW'(cnt_ff);
   assign warm         = (cnt_w < CW'(warmup_ff));
   assign stall_hit    = (cnt_w > CW'(stall_cnt_ff)) && (sigma_ff < floor_ff)
                         && (mean_ff < stall_mean_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE:      if (req_take && enable_ff) st_in = S_EFF_GO;
         S_EFF_GO:    st_in = S_EFF_WAIT;
         S_EFF_WAIT:  if (it_status.done) st_in = S_SIZE_GO;
         S_SIZE_GO:   st_in = S_SIZE_WAIT;
         S_SIZE_WAIT: if (it_status.done) st_in = S_SCORE;
         S_SCORE:     st_in = first_sample ? S_OUT : S_MEAN;
         S_MEAN:      st_in = S_SQ;
         S_SQ:        st_in = S_T1;
         S_T1:        st_in = S_DEV2;
         S_DEV2:      st_in = S_T2;
         S_T2:        st_in = S_ROOT_GO;
         S_ROOT_GO:   st_in = S_ROOT_WAIT;
         S_ROOT_WAIT: if (it_status.done) st_in = S_CHECK;
         S_CHECK:     st_in = warm ? S_OUT : S_DEN;
         S_DEN:       st_in = S_QUOT_GO;
         S_QUOT_GO: begin
            if (mag_ff == '0 || {5'd0, mag_ff, 7'd0} >= den_ff) st_in = S_FINAL;
            else st_in = S_QUOT_WAIT;
         end
         S_QUOT_WAIT: if (it_status.done) st_in = S_FINAL;
         S_FINAL:     st_in = S_OUT;
         S_OUT:       if (rsp_if.ready) st_in = S_IDLE;
         default:     st_in = S_IDLE;
      endcase
   end

   // unit and multiplier operand selection
   always_comb begin
      it_ctrl.start = 1'b0;
      it_ctrl.op    = OP_DIV;
      it_rem0       = {7'd0, w_ff, 6'd0};
      it_den        = {5'd0, 7'd0, w_ff} + {12'd0, e_ff} + {6'd0, w_ff, 6'd0} + 28'd64
                      - {12'd0, w_ff};
      mul_a         = {1'b0, smoothing_ff};
      mul_b         = {16'd0, dev_mag_ff};
      case (st_ff)
         S_EFF_GO: begin
            it_ctrl.start = 1'b1;
         end
         S_SIZE_GO: begin
            it_ctrl.start = 1'b1;
            it_rem0       = {13'd0, w_ff};
            it_den        = {12'd0, w_ff} + 28'd4;
         end
         S_ROOT_GO: begin
            it_ctrl.start = 1'b1;
            it_ctrl.op    = OP_SQRT;
         end
         S_QUOT_GO: begin
            it_ctrl.start = (mag_ff != '0) && ({5'd0, mag_ff, 7'd0} < den_ff);
            it_rem0       = {6'd0, mag_ff, 7'd0};
            it_den        = den_ff;
         end
         S_SQ: begin
            mul_a = {1'b0, sigma_ff};
            mul_b = {16'd0, sigma_ff};
         end
         S_T1: begin
            mul_a = 17'h10000 - {1'b0, smoothing_ff};
            mul_b = prod_ff;
         end
         S_DEV2: begin
            mul_a = {1'b0, dev_mag_ff};
         end
         S_T2: begin
            mul_b = prod_ff;
         end
         S_DEN: begin
            mul_a = {5'd0, band_ff};
            mul_b = {16'd0, sig_sel};
         end
         default: ;
      endcase
   end

   assign mul_p = 49'(mul_a) * 49'(mul_b);

   eda_iter_unit u_iter (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (it_ctrl),
      .div_rem0 (it_rem0),
      .div_den  (it_den),
      .sqrt_val (acc_ff[47:16]),
      .status   (it_status),
      .result   (it_result)
   );

   // score, deviation and mean update
   always_comb begin
      score_sum = {1'b0, eff_ff} + {1'b0, it_result};
      score_c   = score_sum[16:1];
      dev_c     = {1'b0, score_c} - {1'b0, mean_ff};
      p_ceil    = {1'b0, mul_p[32:0]} + 34'd65535;
      if (dev_neg_ff) mean_new = {3'd0, mean_ff} - {1'b0, p_ceil[33:16]};
      else            mean_new = {3'd0, mean_ff} + {2'd0, mul_p[32:16]};
      if (mean_new < 0)                  mean_sat = '0;
      else if (mean_new > 19'sd65535)    mean_sat = 16'hFFFF;
      else                               mean_sat = mean_new[15:0];
      sig_sel   = (sigma_ff < floor_ff) ? floor_ff : sigma_ff;
      num_c     = {1'b0, score_ff} - {1'b0, mean_ff};
   end

   // datapath updates
   always_comb begin
      e_in       = e_ff;
      w_in       = w_ff;
      eff_in     = eff_ff;
      score_in   = score_ff;
      dev_neg_in = dev_neg_ff;
      dev_mag_in = dev_mag_ff;
      mean_in    = mean_ff;
      sigma_in   = sigma_ff;
      cnt_in     = cnt_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      den_in     = den_ff;
      num_neg_in = num_neg_ff;
      mag_in     = mag_ff;
      q_in       = q_ff;
      reg_in     = reg_ff;
      case (st_ff)
         S_IDLE: begin
            // negative counts clamp to zero
            e_in = req_if.edge_count[16] ? 16'd0 : req_if.edge_count[15:0];
            w_in = req_if.word_count[16] ? 16'd0 : req_if.word_count[15:0];
         end
         S_EFF_WAIT: if (it_status.done) eff_in = it_result;
         S_SCORE: begin
            score_in   = score_c;
            dev_neg_in = dev_c[16];
            dev_mag_in = dev_c[16] ? 16'(17'd0 - dev_c) : dev_c[15:0];
            if (first_sample) begin
               mean_in  = score_c;
               sigma_in = '0;
               cnt_in   = COUNT_BITS'(1);
               reg_in   = '0;
            end
         end
         S_MEAN:  mean_in = mean_sat;
         S_SQ:    prod_in = mul_p[31:0];
         S_T1:    acc_in  = mul_p;
         S_DEV2:  prod_in = mul_p[31:0];
         S_T2:    acc_in  = acc_ff + mul_p;
         S_ROOT_WAIT: begin
            if (it_status.done) begin
               sigma_in = it_result;
               if (cnt_ff != '1) cnt_in = cnt_ff + COUNT_BITS'(1);
            end
         end
         S_CHECK: begin
            reg_in     = '0;
            num_neg_in = num_c[16];
            mag_in     = num_c[16] ? 16'(17'd0 - num_c) : num_c[15:0];
         end
         S_DEN: den_in = mul_p[27:0];
         S_QUOT_GO: begin
            if (mag_ff == '0) q_in = '0;
            else q_in = Q_ONE;
         end
         S_QUOT_WAIT: begin
            if (it_status.done) q_in = (it_result > Q_ONE) ? Q_ONE : it_result;
         end
         S_FINAL: begin
            if (stall_hit)       reg_in = stall_push_ff;
            else if (num_neg_ff) reg_in = (q_ff == Q_ONE) ? Q_MAX_POS : q_ff;
            else                 reg_in = 16'(17'd0 - {1'b0, q_ff});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         mean_ff  <= '0;
         sigma_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         st_ff    <= st_in;
         mean_ff  <= mean_in;
         sigma_ff <= sigma_in;
         cnt_ff   <= cnt_in;
      end
      e_ff       <= e_in;
      w_ff       <= w_in;
      eff_ff     <= eff_in;
      score_ff   <= score_in;
      dev_neg_ff <= dev_neg_in;
      dev_mag_ff <= dev_mag_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      den_ff     <= den_in;
      num_neg_ff <= num_neg_in;
      mag_ff     <= mag_in;
      q_ff       <= q_in;
      reg_ff     <= reg_in;
   end

   // channel outputs
   assign req_if.ready      = (st_ff == S_IDLE);
   assign rsp_if.valid      = (st_ff == S_OUT);
   assign rsp_if.score      = score_ff;
   assign rsp_if.regulation = reg_ff;
   assign rsp_if.mean_now   = mean_ff;
   assign rsp_if.sigma_now  = sigma_ff;
   assign rsp_if.count_now  = (cnt_w > CW'(16'hFFFF)) ? 16'hFFFF : cnt_w[15:0];

   `EDA_CHECK(a_no_start_while_busy, it_ctrl.start |-> !it_status.busy, "iterative unit started while busy")
   `EDA_CHECK(a_count_monotonic, cnt_ff >= $past(cnt_ff), "sample count went down")
   `EDA_CHECK(a_first_sample_zero_drive, (rsp_if.valid && cnt_ff == COUNT_BITS'(1)) |-> (reg_ff == '0), "first sample drives regulation")

endmodule

`default_nettype wire

[rtl/eda_iter_unit.sv]
`default_nettype none
`include "ema_deviation_regulator_macros.svh"

// shared restoring divider / square root, one result bit per cycle, 16 result bits
module eda_iter_unit import eda_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire iter_ctrl_type   ctrl,
   input  wire logic [28:0]     div_rem0,
   input  wire logic [27:0]     div_den,
   input  wire logic [31:0]     sqrt_val,
   output iter_status_type      status,
   output logic [15:0]          result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   iter_op_type op_ff, op_in;
   logic [3:0]  step_ff, step_in;
   logic [28:0] rem_ff, rem_in;
   logic [27:0] den_ff, den_in;
   logic [31:0] val_ff, val_in;
   logic [15:0] res_ff, res_in;

   logic [29:0] opnd_a;
   logic [29:0] opnd_b;
   logic [29:0] diff;
   logic        geq;

   // shared compare and subtract
   always_comb begin
      if (op_ff == OP_DIV) begin
         opnd_a = {rem_ff, 1'b0};
         opnd_b = {2'b00, den_ff};
      end else begin
         opnd_a = {12'd0, rem_ff[15:0], val_ff[31:30]};
         opnd_b = {12'd0, res_ff, 2'b01};
      end
      diff = opnd_a - opnd_b;
      geq  = (opnd_a >= opnd_b);
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      val_in  = val_ff;
      res_in  = res_ff;
      if (ctrl.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = ctrl.op;
         step_in = '0;
         rem_in  = (ctrl.op == OP_DIV) ? div_rem0 : 29'd0;
         den_in  = div_den;
         val_in  = sqrt_val;
         res_in  = '0;
      end else if (busy_ff) begin
         rem_in  = geq ? diff[28:0] : opnd_a[28:0];
         res_in  = {res_ff[14:0], geq};
         val_in  = {val_ff[29:0], 2'b00};
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_DIV;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      val_ff <= val_in;
      res_ff <= res_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = res_ff;

   `EDA_CHECK(a_div_rem_below_den, (busy_ff && op_ff == OP_DIV) |-> (rem_ff < {1'b0, den_ff}), "divider remainder reached divisor")
   `EDA_CHECK(a_sqrt_rem_bound, (busy_ff && op_ff == OP_SQRT) |-> (rem_ff <= {12'd0, res_ff, 1'b0}), "root remainder above twice the root")
   `EDA_CHECK(a_done_ends_run, done_ff |-> (!busy_ff && $past(busy_ff)), "done without a finished run")

endmodule

`default_nettype wire

[tb/ema_deviation_regulator_tb.sv]
`default_nettype none

module ema_deviation_regulator_tb import eda_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // one expected result word
   typedef struct {
      logic        [15:0] score;
      logic signed [15:0] regulation;
      logic        [15:0] mean_now;
      logic        [15:0] sigma_now;
      logic        [15:0] count_now;
   } result_word_type;

   // tracks mean, sigma and count and holds the words still owed by the block
   class regulator_scoreboard;
      result_word_type owed[$];
      int unsigned  errors;
      int unsigned  words_in;
      int unsigned  words_out;
      // register mirror
      bit           en;
      longint       rate, band, floor_sig, warmup, stall_cnt, stall_avg, push;
      // moving statistics
      longint       avg, sig, samples;

      function new();
         en = RST_ENABLE;
         rate = RST_SMOOTHING;
         band = RST_BAND_SCALE;
         floor_sig = RST_SIGMA_FLOOR;
         warmup = RST_WARMUP;
         stall_cnt = RST_STALL_COUNT;
         stall_avg = RST_STALL_MEAN;
         push = $signed(RST_STALL_PUSH);
         avg = 0;
         sig = 0;
         samples = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] v);
         case (idx)
            REG_ENABLE:      en = v[0];
            REG_SMOOTHING:   rate = v[15:0];
            REG_BAND_SCALE:  band = v[11:0];
            REG_SIGMA_FLOOR: floor_sig = v[15:0];
            REG_WARMUP:      warmup = v[15:0];
            REG_STALL_COUNT: stall_cnt = v[15:0];
            REG_STALL_MEAN:  stall_avg = v[15:0];
            REG_STALL_PUSH:  push = $signed(v[15:0]);
            default: ;
         endcase
      endfunction

      // integer square root, bit by bit
      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // accepted input word: update the statistics and owe a result if enabled
      function void note_word(logic signed [16:0] ec, logic signed [16:0] wc);
         longint unsigned e, w, eff, sz, varq, den, mag, q;
         longint          score, dev, m, num, d, regv, s;
         result_word_type r;
         words_in++;
         if (!en) return;
         e = ec[16] ? 0 : ec[15:0];
         w = wc[16] ? 0 : wc[15:0];
         eff = (64 * w * 65536) / (64 * w + e + 64);
         sz = (w * 65536) / (w + 4);
         score = (eff + sz) >> 1;
         regv = 0;
         if (samples == 0) begin
            avg = score;
            sig = 0;
            samples = 1;
         end else begin
            dev = score - avg;
            m = avg + ((rate * dev) >>> 16);
            if (m < 0) m = 0;
            if (m > 65535) m = 65535;
            avg = m;
            varq = ((65536 - rate) * sig * sig + rate * dev * dev) >> 16;
            sig = int_sqrt(varq);
            if (sig > 65535) sig = 65535;
            if (samples < 65535) samples++;
            if (samples >= warmup) begin
               s = (sig < floor_sig) ? floor_sig : sig;
               den = band * s;
               num = score - avg;
               mag = (num < 0) ? -num : num;
               if (den == 0) q = (mag != 0) ? 32768 : 0;
               else q = (mag << 23) / den;
               if (q > 32768) q = 32768;
               d = (num < 0) ? -longint'(q) : longint'(q);
               regv = -d;
               if (regv > 32767) regv = 32767;
               // degenerate: long run, flat sigma, low mean
               if (samples > stall_cnt && sig < floor_sig && avg < stall_avg)
                  regv = push;
            end
         end
         r.score = score[15:0];
         r.regulation = regv[15:0];
         r.mean_now = avg[15:0];
         r.sigma_now = sig[15:0];
         r.count_now = samples[15:0];
         owed.push_back(r);
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         $display("mismatch at result %0d: %s got %0d expected %0d", words_out, what, got,
                  want);
      endtask

      task check_word(result_word_type got);
         result_word_type want;
         words_out++;
         if (owed.size() == 0) begin
            errors++;
            $display("result %0d arrived with nothing expected", words_out);
            return;
         end
         want = owed.pop_front();
         if (got.score !== want.score) report("score", got.score, want.score);
         if (got.regulation !== want.regulation)
            report("regulation", got.regulation, want.regulation);
         if (got.mean_now !== want.mean_now) report("mean_now", got.mean_now, want.mean_now);
         if (got.sigma_now !== want.sigma_now)
            report("sigma_now", got.sigma_now, want.sigma_now);
         if (got.count_now !== want.count_now)
            report("count_now", got.count_now, want.count_now);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite, pready;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;

   eda_req_if req_if();
   eda_rsp_if rsp_if();

   regulator_scoreboard sb;
   int unsigned idle_cycles;
   int unsigned sent;
   bit          quiet_send;

   ema_deviation_regulator dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // result monitor
   always @(posedge clock) begin
      result_word_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.score = rsp_if.score;
         got.regulation = rsp_if.regulation;
         got.mean_now = rsp_if.mean_now;
         got.sigma_now = rsp_if.sigma_now;
         got.count_now = rsp_if.count_now;
         sb.check_word(got);
      end
   end

   // receiver: random stalls, one long hold-off, one stretch always ready
   initial begin
      int unsigned cyc;
      cyc = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) cyc++;
         if (cyc >= 4000 && cyc < 4400) rsp_if.ready <= 1'b0;
         else if (cyc >= 9000 && cyc < 13000) rsp_if.ready <= 1'b1;
         else rsp_if.ready <= ($urandom_range(0, 99) >= 32);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable && pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("status: fail");
         $finish;
      end
   end

   // register write, setup then access; the caller ends the transfer
   task csr_write(reg_index_type idx, logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, v);
   endtask

   task write_all(logic [31:0] en, logic [31:0] a, logic [31:0] k, logic [31:0] fl,
                  logic [31:0] wu, logic [31:0] sc, logic [31:0] sm, logic [31:0] sp);
      csr_write(REG_ENABLE, en);
      csr_write(REG_SMOOTHING, a);
      csr_write(REG_BAND_SCALE, k);
      csr_write(REG_SIGMA_FLOOR, fl);
      csr_write(REG_WARMUP, wu);
      csr_write(REG_STALL_COUNT, sc);
      csr_write(REG_STALL_MEAN, sm);
      csr_write(REG_STALL_PUSH, sp);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // one input word, with random gaps before it outside the quiet stretch
   task send_word(logic signed [16:0] ec, logic signed [16:0] wc);
      while (!quiet_send && $urandom_range(0, 99) < 32) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.edge_count <= ec;
      req_if.word_count <= wc;
      do @(posedge clock); while (!req_if.ready);
      sb.note_word(ec, wc);
      sent++;
      quiet_send = (sent >= 600 && sent < 800);
   endtask

   // wait for every owed result, then let the block settle
   task drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function logic signed [16:0] rand_count();
      case ($urandom_range(0, 9))
         0: return 17'(-$signed({1'b0, 16'($urandom_range(1, 65536) - 1)}) - 1);
         1: return 17'($urandom());
         2: return ($urandom_range(0, 1) != 0) ? 17'sd65535 : 17'sd0;
         3, 4: return 17'($urandom_range(0, 65535));
         default: return 17'($urandom_range(0, 300));
      endcase
   endfunction

   task random_words(int n);
      repeat (n) send_word(rand_count(), rand_count());
   endtask

   initial begin
      int dir_e[$];
      int dir_w[$];
      sb = new();
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.edge_count = '0;
      req_if.word_count = '0;
      idle_cycles = 0;
      sent = 0;
      quiet_send = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero counts, extremes, negatives clamped, first sample seeding
      dir_e = '{0, 65535, 0, 65535, -65536, -1, 1, 0, 100, 65535, -65536, 7, 0, 64, 3, 0,
                1000, -5, 65535, 0};
      dir_w = '{0, 65535, 65535, 0, 10, -65536, 1, 4, 100, -1, -65536, 0, 1, 1, 65535,
                2, 1, 300, 1, 0};
      foreach (dir_e[i]) send_word(17'(dir_e[i]), 17'(dir_w[i]));
      drain();

      // disabled: words are dropped
      write_all(0, 3277, 512, 1311, 20, 200, 22938, 16384);
      random_words(30);
      drain();

      // fastest learning, narrowest band, no sigma floor
      write_all(1, 65535, 1, 0, 0, 65535, 0, 32'hFFFF8000);
      random_words(140);
      drain();

      // frozen statistics, widest band, regulation held at zero by warm-up
      write_all(1, 0, 4095, 65535, 65535, 65535, 65535, 32767);
      random_words(120);
      drain();

      // degenerate push always applies
      write_all(1, 0, 2048, 65535, 0, 0, 65535, 32767);
      random_words(120);
      drain();

      // back to defaults, with long uninterrupted runs
      write_all(1, 3277, 512, 1311, 20, 200, 22938, 16384);
      random_words(300);
      drain();

      // random settings
      repeat (6) begin
         write_all(1, $urandom_range(0, 65535), $urandom_range(1, 4095),
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535),
                   $urandom_range(0, 40), $urandom_range(0, 300), $urandom_range(0, 65535),
                   {16'h0, 16'($urandom())});
         random_words(125);
         drain();
      end

      $display("sent %0d input words (%0d while disabled), checked %0d results",
               sb.words_in, 30, sb.words_out);
      $display("covered default, extreme, degenerate-push and random register settings");
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/eda_pkg.sv
rtl/eda_ifaces.sv
rtl/eda_iter_unit.sv
rtl/ema_deviation_regulator.sv
tb/ema_deviation_regulator_tb.sv
